FILE: hdl/ssq_pkg.sv
`default_nettype none

package ssq_pkg;

	localparam int CAPACITY  = 16;
	localparam int ID_BITS   = 8;
	localparam int WAKE_BITS = 64;
	localparam int OID_BITS  = 8;
	localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int SUM_W     = CNT_W + 1;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [ID_BITS-1:0]   id_t;
	typedef logic [OID_BITS-1:0]  oid_t;
	typedef logic [WAKE_BITS-1:0] wake_t;
	typedef logic [2:0]           stat_t;
	typedef logic [1:0]           req_t;

	localparam req_t REQ_INSERT = 2'd0;
	localparam req_t REQ_REMOVE = 2'd1;
	localparam req_t REQ_TICK   = 2'd2;

	localparam stat_t STAT_WOKEN     = 3'd0;
	localparam stat_t STAT_INSERTED  = 3'd1;
	localparam stat_t STAT_FULL      = 3'd2;
	localparam stat_t STAT_REMOVED   = 3'd3;
	localparam stat_t STAT_NOT_FOUND = 3'd4;
	localparam stat_t STAT_NOTHING   = 3'd5;

	typedef struct packed {
		stat_t status;
		oid_t  woken_id;
		logic  last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_REM_RD,
		S_REM_CMP,
		S_SH_RD,
		S_SH_WR,
		S_TCK_RD,
		S_TCK_CMP,
		S_EMIT_OUT,
		S_DONE
	} state_t;

	// Maps a queue position to a slot of the circular store.
	function automatic addr_t phys_addr(addr_t head, cnt_t lidx);
		sum_t sum;
		sum = sum_t'(head) + sum_t'(lidx);
		if (sum >= sum_t'(CAPACITY)) begin
			sum = sum - sum_t'(CAPACITY);
		end
		return addr_t'(sum);
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ssq_out.sv
`default_nettype none

module ssq_out
	import ssq_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       up_valid,
	output logic      up_stall,
	input  wire res_t up_res,
	output logic      dn_valid,
	input  wire       dn_stall,
	output res_t      dn_res
);

	logic full_q;
	res_t res_q;

	assign up_stall = full_q & dn_stall;
	assign dn_valid = full_q;
	assign dn_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (!up_stall) begin
			full_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			res_q <= up_res;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ssq_engine.sv
`default_nettype none

module ssq_engine
	import ssq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_stall,
	input  wire  [1:0] req_type,
	input  wire  [7:0] thread_id,
	input  wire [63:0] wake_time,
	input  wire [63:0] now_time,
	output logic       res_valid,
	input  wire        res_stall,
	output res_t       res
);

	state_t state_q, state_d;
	addr_t  head_q, head_d;
	cnt_t   occ_q, occ_d;
	cnt_t   idx_q, idx_d;
	cnt_t   cnt_q, cnt_d;
	stat_t  stat_q, stat_d;
	id_t    id_q;
	wake_t  key_q;

	wake_t  mem_wake [CAPACITY];
	id_t    mem_id [CAPACITY];
	wake_t  rd_wake_q;
	id_t    rd_id_q;

	cnt_t   rd_lidx, wr_lidx;
	addr_t  rd_addr, wr_addr;
	logic   wr_en;
	wake_t  wr_wake;
	id_t    wr_id;
	cnt_t   idx_p1, idx_p2, idx_m1;
	logic   wake_gt;
	logic   accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign idx_p1    = idx_q + cnt_t'(1);
	assign idx_p2    = idx_q + cnt_t'(2);
	assign idx_m1    = idx_q - cnt_t'(1);
	// The one 64-bit comparator, shared by insert and tick.
	assign wake_gt   = (rd_wake_q > key_q);
	assign rd_addr   = phys_addr(head_q, rd_lidx);
	assign wr_addr   = phys_addr(head_q, wr_lidx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			stat_q  <= STAT_NOTHING;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			occ_q   <= occ_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			stat_q  <= stat_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= id_t'(thread_id);
			key_q <= (req_type == REQ_TICK) ? now_time : wake_time;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_wake[wr_addr] <= wr_wake;
			mem_id[wr_addr]   <= wr_id;
		end
		rd_wake_q <= mem_wake[rd_addr];
		rd_id_q   <= mem_id[rd_addr];
	end

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		occ_d        = occ_q;
		idx_d        = idx_q;
		cnt_d        = cnt_q;
		stat_d       = stat_q;
		rd_lidx      = idx_q;
		wr_lidx      = idx_q;
		wr_en        = 1'b0;
		wr_wake      = rd_wake_q;
		wr_id        = rd_id_q;
		res_valid    = 1'b0;
		res.status   = stat_q;
		res.woken_id = '0;
		res.last     = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_d = '0;
					unique case (req_type)
						REQ_INSERT: begin
							if (occ_q == cnt_t'(CAPACITY)) begin
								stat_d  = STAT_FULL;
								state_d = S_DONE;
							end else begin
								idx_d   = occ_q;
								state_d = (occ_q == '0) ? S_INS_PUT : S_INS_RD;
							end
						end
						REQ_REMOVE: begin
							if (occ_q == '0) begin
								stat_d  = STAT_NOT_FOUND;
								state_d = S_DONE;
							end else begin
								state_d = S_REM_RD;
							end
						end
						REQ_TICK: begin
							if (occ_q == '0) begin
								stat_d  = STAT_NOTHING;
								state_d = S_DONE;
							end else begin
								state_d = S_TCK_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INS_RD: begin
				rd_lidx = idx_m1;
				state_d = S_INS_CMP;
			end
			S_INS_CMP: begin
				if (wake_gt) begin
					wr_en   = 1'b1;
					idx_d   = idx_m1;
					state_d = (idx_q == cnt_t'(1)) ? S_INS_PUT : S_INS_RD;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				wr_en   = 1'b1;
				wr_wake = key_q;
				wr_id   = id_q;
				occ_d   = occ_q + cnt_t'(1);
				stat_d  = STAT_INSERTED;
				state_d = S_DONE;
			end
			S_REM_RD: begin
				state_d = S_REM_CMP;
			end
			S_REM_CMP: begin
				if (rd_id_q == id_q) begin
					if (idx_p1 == occ_q) begin
						occ_d   = occ_q - cnt_t'(1);
						stat_d  = STAT_REMOVED;
						state_d = S_DONE;
					end else begin
						state_d = S_SH_RD;
					end
				end else if (idx_p1 == occ_q) begin
					stat_d  = STAT_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					idx_d   = idx_p1;
					state_d = S_REM_RD;
				end
			end
			S_SH_RD: begin
				rd_lidx = idx_p1;
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				wr_en = 1'b1;
				idx_d = idx_p1;
				if (idx_p2 == occ_q) begin
					occ_d   = occ_q - cnt_t'(1);
					stat_d  = STAT_REMOVED;
					state_d = S_DONE;
				end else begin
					state_d = S_SH_RD;
				end
			end
			S_TCK_RD: begin
				state_d = S_TCK_CMP;
			end
			S_TCK_CMP: begin
				if (!wake_gt) begin
					if (idx_p1 == occ_q) begin
						cnt_d   = idx_p1;
						idx_d   = '0;
						rd_lidx = '0;
						state_d = S_EMIT_OUT;
					end else begin
						idx_d   = idx_p1;
						state_d = S_TCK_RD;
					end
				end else if (idx_q == '0) begin
					stat_d  = STAT_NOTHING;
					state_d = S_DONE;
				end else begin
					cnt_d   = idx_q;
					idx_d   = '0;
					rd_lidx = '0;
					state_d = S_EMIT_OUT;
				end
			end
			S_EMIT_OUT: begin
				res_valid    = 1'b1;
				res.status   = STAT_WOKEN;
				res.woken_id = oid_t'(rd_id_q);
				res.last     = (idx_p1 == cnt_q);
				if (!res_stall) begin
					if (idx_p1 == cnt_q) begin
						head_d  = phys_addr(head_q, cnt_q);
						occ_d   = occ_q - cnt_q;
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_p1;
						rd_lidx = idx_p1;
					end
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (!res_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cnt_t'(CAPACITY))
		else $error("occupancy above capacity");

	a_occ_change: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> ($past(state_q) == S_INS_PUT ||
			$past(state_q) == S_REM_CMP || $past(state_q) == S_SH_WR ||
			$past(state_q) == S_EMIT_OUT))
		else $error("occupancy changed outside an update step");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_OUT) |-> (idx_q < cnt_q && cnt_q <= occ_q))
		else $error("woken item index out of range");

	a_ins_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_CMP || state_q == S_INS_RD) |-> (idx_q != '0))
		else $error("insert scan passed the queue front");

endmodule

`default_nettype wire

FILE: hdl/sorted_sleep_queue.sv
// Insert: entries are compared from the back, each later one moved back, then
// the new one is stored, then the result item. A full queue answers at once.
// Remove: entries are searched from the front; later ones then move forward.
// Tick: entries are compared from the front, then one woken item per cycle
// while the output is not stalled. A new request is taken only after the last
// result item has been handed to the output register. Reset empties the queue.
`default_nettype none

module sorted_sleep_queue
	import ssq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_stall,
	input  wire  [1:0] req_type,
	input  wire  [7:0] thread_id,
	input  wire [63:0] wake_time,
	input  wire [63:0] now_time,
	output logic       res_valid,
	input  wire        res_stall,
	output logic [2:0] status,
	output logic [7:0] woken_id,
	output logic       last
);

	logic eng_valid;
	logic eng_stall;
	res_t eng_res;
	res_t out_res;

	ssq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.thread_id (thread_id),
		.wake_time (wake_time),
		.now_time  (now_time),
		.res_valid (eng_valid),
		.res_stall (eng_stall),
		.res       (eng_res)
	);

	ssq_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (eng_valid),
		.up_stall (eng_stall),
		.up_res   (eng_res),
		.dn_valid (res_valid),
		.dn_stall (res_stall),
		.dn_res   (out_res)
	);

	assign status   = out_res.status;
	assign woken_id = out_res.woken_id;
	assign last     = out_res.last;

endmodule

`default_nettype wire
